@@ sv/qtm_pkg.sv @@
// Package with the word types, widths and constants of the transform-to-matrix block.
`default_nettype none

package qtm_pkg;

    // Widths of the fixed-point formats used along the datapath.
    localparam int QUAT_W  = 16;   // Q1.15 quaternion component
    localparam int SCL_W   = 16;   // Q8.8 scale
    localparam int PROD_W  = 2 * QUAT_W;        // Q2.30 raw product
    localparam int ENT_W   = PROD_W + 2;        // doubled, summed Q2.30 entry
    localparam int MUL_W   = ENT_W + SCL_W;     // Q.38 scaled entry
    localparam int DROP_W  = 22;                // fraction bits dropped to reach Q16.16
    localparam int SHR_W   = MUL_W - DROP_W;    // width left after the drop
    localparam int OUT_W   = 32;                // Q16.16 result
    localparam int LATENCY = 4;                 // register stages from start to strobe
    localparam int N_ENT   = 9;                 // rotation entries in the 3x3 block
    localparam int N_AXIS  = 3;

    // 1.0 in Q2.30, at entry width.
    localparam logic signed [ENT_W-1:0] ONE_Q30 = ENT_W'(64'd1 << 30);
    // Half of the last kept bit, for round half toward plus infinity.
    localparam logic signed [MUL_W-1:0] RND_HALF = MUL_W'(64'd1 << (DROP_W - 1));

    // Input word: one transform.
    typedef struct packed {
        logic signed [QUAT_W-1:0] quat_x;
        logic signed [QUAT_W-1:0] quat_y;
        logic signed [QUAT_W-1:0] quat_z;
        logic signed [QUAT_W-1:0] quat_w;
        logic signed [SCL_W-1:0]  scale_x;
        logic signed [SCL_W-1:0]  scale_y;
        logic signed [SCL_W-1:0]  scale_z;
        logic signed [OUT_W-1:0]  move_x;
        logic signed [OUT_W-1:0]  move_y;
        logic signed [OUT_W-1:0]  move_z;
    } t_in;

    // Result word: the 3x4 affine part of the matrix.
    typedef struct packed {
        logic signed [OUT_W-1:0] m_xx;
        logic signed [OUT_W-1:0] m_xy;
        logic signed [OUT_W-1:0] m_xz;
        logic signed [OUT_W-1:0] m_yx;
        logic signed [OUT_W-1:0] m_yy;
        logic signed [OUT_W-1:0] m_yz;
        logic signed [OUT_W-1:0] m_zx;
        logic signed [OUT_W-1:0] m_zy;
        logic signed [OUT_W-1:0] m_zz;
        logic signed [OUT_W-1:0] m_wx;
        logic signed [OUT_W-1:0] m_wy;
        logic signed [OUT_W-1:0] m_wz;
    } t_out;

    // Translation carried alongside the arithmetic.
    typedef struct packed {
        logic signed [OUT_W-1:0] move_x;
        logic signed [OUT_W-1:0] move_y;
        logic signed [OUT_W-1:0] move_z;
    } t_move;

    // Twice a Q2.30 product, sign-extended to entry width.
    function automatic logic signed [ENT_W-1:0] dbl(input logic signed [PROD_W-1:0] p);
        dbl = {p[PROD_W-1], p, 1'b0};
    endfunction

endpackage

`default_nettype wire

@@ sv/quaternion_transform_to_matrix.sv @@
// A word taken with start appears on o_result with o_valid once it leaves the last stage.
// Throughput: one word per cycle; busy is never raised, the four-stage pipeline
// (products, entry sums, scale multiply, rounding) accepts a new word every cycle.
// Each result is shown for exactly one cycle; the receiver cannot hold it off.
// Reset (synchronous, active low) clears the stage valid bits, so no strobe follows reset.
`default_nettype none

module quaternion_transform_to_matrix
    import qtm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in  i_item,
    output logic      o_valid,
    output t_out      o_result
);

    logic                     w_accept;
    logic [LATENCY-1:0]       r_valid;
    logic [LATENCY-1:0]       n_valid;

    // Stage one: raw quaternion products.
    logic signed [PROD_W-1:0] r_p_xx, r_p_yy, r_p_zz, r_p_xy, r_p_xz;
    logic signed [PROD_W-1:0] r_p_yz, r_p_wx, r_p_wy, r_p_wz;
    logic signed [SCL_W-1:0]  r_s1_scale [N_AXIS];
    // Stage two: rotation entries in Q2.30.
    logic signed [ENT_W-1:0]  r_ent [N_ENT];
    logic signed [ENT_W-1:0]  n_ent [N_ENT];
    logic signed [SCL_W-1:0]  r_s2_scale [N_AXIS];
    // Translation delay line, one tap per stage.
    t_move                    r_move [LATENCY];
    logic signed [OUT_W-1:0]  w_word [N_ENT];

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // Valid bits travel with the data.
    assign n_valid = {r_valid[LATENCY-2:0], w_accept};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Products and the first translation tap.
    always_ff @(posedge i_clk) begin
        r_p_xx        <= i_item.quat_x * i_item.quat_x;
        r_p_yy        <= i_item.quat_y * i_item.quat_y;
        r_p_zz        <= i_item.quat_z * i_item.quat_z;
        r_p_xy        <= i_item.quat_x * i_item.quat_y;
        r_p_xz        <= i_item.quat_x * i_item.quat_z;
        r_p_yz        <= i_item.quat_y * i_item.quat_z;
        r_p_wx        <= i_item.quat_w * i_item.quat_x;
        r_p_wy        <= i_item.quat_w * i_item.quat_y;
        r_p_wz        <= i_item.quat_w * i_item.quat_z;
        r_s1_scale[0] <= i_item.scale_x;
        r_s1_scale[1] <= i_item.scale_y;
        r_s1_scale[2] <= i_item.scale_z;
        r_move[0]     <= '{move_x: i_item.move_x, move_y: i_item.move_y,
                           move_z: i_item.move_z};
    end

    // Doubled products combined into the nine rotation entries.
    always_comb begin
        n_ent[0] = ONE_Q30 - (dbl(r_p_yy) + dbl(r_p_zz));
        n_ent[1] = dbl(r_p_xy) + dbl(r_p_wz);
        n_ent[2] = dbl(r_p_xz) - dbl(r_p_wy);
        n_ent[3] = dbl(r_p_xy) - dbl(r_p_wz);
        n_ent[4] = ONE_Q30 - (dbl(r_p_xx) + dbl(r_p_zz));
        n_ent[5] = dbl(r_p_yz) + dbl(r_p_wx);
        n_ent[6] = dbl(r_p_xz) + dbl(r_p_wy);
        n_ent[7] = dbl(r_p_yz) - dbl(r_p_wx);
        n_ent[8] = ONE_Q30 - (dbl(r_p_xx) + dbl(r_p_yy));
    end

    always_ff @(posedge i_clk) begin
        r_ent      <= n_ent;
        r_s2_scale <= r_s1_scale;
    end

    // Remaining translation taps.
    always_ff @(posedge i_clk) begin
        for (int i = 1; i < LATENCY; i++) begin
            r_move[i] <= r_move[i-1];
        end
    end

    // Scale multiply and rounding, one unit per entry, row scale by entry row.
    for (genvar g = 0; g < N_ENT; g++) begin : g_ent
        qtm_scale_round u_scale_round (
            .i_clk   (i_clk),
            .i_entry (r_ent[g]),
            .i_scale (r_s2_scale[g / N_AXIS]),
            .o_word  (w_word[g])
        );
    end

    // Result word and strobe.
    assign o_valid         = r_valid[LATENCY-1];
    assign o_result.m_xx   = w_word[0];
    assign o_result.m_xy   = w_word[1];
    assign o_result.m_xz   = w_word[2];
    assign o_result.m_yx   = w_word[3];
    assign o_result.m_yy   = w_word[4];
    assign o_result.m_yz   = w_word[5];
    assign o_result.m_zx   = w_word[6];
    assign o_result.m_zy   = w_word[7];
    assign o_result.m_zz   = w_word[8];
    assign o_result.m_wx   = r_move[LATENCY-1].move_x;
    assign o_result.m_wy   = r_move[LATENCY-1].move_y;
    assign o_result.m_wz   = r_move[LATENCY-1].move_z;

    // A taken word always yields a strobe on o_valid.
    a_start_to_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##4 o_valid)
        else $error("accepted word did not produce a strobe after four cycles");

    // No strobe appears without a matching word taken at the pipeline's entry.
    a_valid_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 4))
        else $error("strobe without a matching accepted word");

    // The x and z translation entries leave unchanged and aligned with their word.
    a_move_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.m_wx == $past(i_item.move_x, 4)) &&
                    (o_result.m_wz == $past(i_item.move_z, 4)))
        else $error("translation row misaligned with its word");

    // A zero quaternion gives zero off-diagonal entries; m_xy, m_yz and m_zx are checked.
    a_zero_quat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_item.quat_x == '0 && i_item.quat_y == '0 &&
                         i_item.quat_z == '0 && i_item.quat_w == '0, 4)
        |-> (o_result.m_xy == '0) && (o_result.m_yz == '0) && (o_result.m_zx == '0))
        else $error("zero quaternion gave non-zero off-diagonal entries");

endmodule

`default_nettype wire

@@ sv/qtm_scale_round.sv @@
// Two-stage scale multiply and rounding of one rotation entry to Q16.16.
`default_nettype none

module qtm_scale_round
    import qtm_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic signed [ENT_W-1:0] i_entry,
    input  wire logic signed [SCL_W-1:0] i_scale,
    output logic signed [OUT_W-1:0]      o_word
);

    logic signed [MUL_W-1:0] r_prod;
    logic signed [MUL_W-1:0] n_prod;
    logic signed [MUL_W-1:0] w_sum;
    logic signed [SHR_W-1:0] w_shr;
    logic signed [OUT_W-1:0] r_word;
    logic signed [OUT_W-1:0] n_word;

    // Exact product of the Q2.30 entry and the Q8.8 scale.
    assign n_prod = MUL_W'(i_entry) * MUL_W'(i_scale);

    // Add half, then floor by an arithmetic shift. The product is at most 2^47
    // in magnitude, so the shifted value always fits the output and cannot saturate.
    assign w_sum  = r_prod + RND_HALF;
    assign w_shr  = w_sum[MUL_W-1:DROP_W];
    assign n_word = OUT_W'(w_shr);

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_word <= n_word;
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

@@ tb/quaternion_transform_to_matrix_tb.sv @@
// Self-checking testbench for the transform-to-matrix block: predicts each matrix word and compares.
`default_nettype none

module quaternion_transform_to_matrix_tb
    import qtm_pkg::*;
();

    localparam longint Q16_MAX = 64'sd2147483647;
    localparam longint Q16_MIN = -64'sd2147483648;
    localparam int RANDOM_PER_PHASE = 440;
    localparam int N_PHASES = 4;
    localparam int MAX_PRINTED = 100;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_in  xform_in = '0;
    logic o_valid;
    t_out o_result;

    t_in  pending_xforms[$];
    t_out awaited_matrices[$];
    int   err_count = 0;
    int   matrices_seen = 0;
    int   idle_pct = 0;

    string field_names [12] = '{"m_xx", "m_xy", "m_xz", "m_yx", "m_yy", "m_yz",
                                "m_zx", "m_zy", "m_zz", "m_wx", "m_wy", "m_wz"};

    quaternion_transform_to_matrix dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (xform_in),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Print one line per mismatch, up to a limit, and count every one.
    task automatic report_error(input string msg);
        if (err_count < MAX_PRINTED) begin
            $display("ERROR: %s", msg);
        end
        err_count++;
    endtask

    // Scale a Q2.30 entry by a Q8.8 factor, round half up to Q16.16 and saturate.
    function automatic logic [31:0] scaled_q16(input longint rot, input longint scl);
        longint p;
        p = rot * scl + (64'sd1 <<< (DROP_W - 1));
        p = p >>> DROP_W;
        if (p > Q16_MAX) begin
            p = Q16_MAX;
        end
        if (p < Q16_MIN) begin
            p = Q16_MIN;
        end
        return p[31:0];
    endfunction

    // Expected matrix word for one transform word.
    function automatic t_out xform_to_matrix(input t_in w);
        longint qx, qy, qz, qw, sx, sy, sz, one;
        longint xx2, yy2, zz2, xy2, xz2, yz2, wx2, wy2, wz2;
        t_out m;
        qx = w.quat_x;
        qy = w.quat_y;
        qz = w.quat_z;
        qw = w.quat_w;
        sx = w.scale_x;
        sy = w.scale_y;
        sz = w.scale_z;
        one = 64'sd1 <<< 30;
        xx2 = 2 * qx * qx;
        yy2 = 2 * qy * qy;
        zz2 = 2 * qz * qz;
        xy2 = 2 * qx * qy;
        xz2 = 2 * qx * qz;
        yz2 = 2 * qy * qz;
        wx2 = 2 * qw * qx;
        wy2 = 2 * qw * qy;
        wz2 = 2 * qw * qz;
        m.m_xx = scaled_q16(one - (yy2 + zz2), sx);
        m.m_xy = scaled_q16(xy2 + wz2, sx);
        m.m_xz = scaled_q16(xz2 - wy2, sx);
        m.m_yx = scaled_q16(xy2 - wz2, sy);
        m.m_yy = scaled_q16(one - (xx2 + zz2), sy);
        m.m_yz = scaled_q16(yz2 + wx2, sy);
        m.m_zx = scaled_q16(xz2 + wy2, sz);
        m.m_zy = scaled_q16(yz2 - wx2, sz);
        m.m_zz = scaled_q16(one - (xx2 + yy2), sz);
        m.m_wx = w.move_x;
        m.m_wy = w.move_y;
        m.m_wz = w.move_z;
        return m;
    endfunction

    // A 16-bit field: mostly full range, often small, sometimes an extreme value.
    function automatic logic [15:0] pick16();
        int r;
        logic [15:0] extremes [7];
        extremes = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h0100, 16'hFF00};
        r = $urandom_range(0, 9);
        if (r < 5) begin
            return 16'($urandom);
        end else if (r < 8) begin
            return 16'($urandom_range(0, 1023)) - 16'd512;
        end
        return extremes[$urandom_range(0, 6)];
    endfunction

    function automatic t_in make_xform(input logic [15:0] qx, qy, qz, qw,
                                       input logic [15:0] sx, sy, sz,
                                       input logic [31:0] mx, my, mz);
        t_in w;
        w.quat_x  = qx;
        w.quat_y  = qy;
        w.quat_z  = qz;
        w.quat_w  = qw;
        w.scale_x = sx;
        w.scale_y = sy;
        w.scale_z = sz;
        w.move_x  = mx;
        w.move_y  = my;
        w.move_z  = mz;
        return w;
    endfunction

    function automatic t_in rand_xform();
        return make_xform(pick16(), pick16(), pick16(), pick16(), pick16(), pick16(), pick16(),
                          $urandom, $urandom, $urandom);
    endfunction

    // Driver: a word is taken at an edge where start is high and busy is low.
    always @(posedge i_clk) begin : driver
        bit took;
        bit hold_off;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            took = start && !busy;
            if (took) begin
                awaited_matrices.push_back(xform_to_matrix(xform_in));
            end
            if (!start || took) begin
                // Random idle cycles at the rate of the current phase.
                hold_off = ($urandom_range(0, 99) < idle_pct);
                if (pending_xforms.size() != 0 && !hold_off) begin
                    xform_in <= pending_xforms.pop_front();
                    start <= 1'b1;
                end else begin
                    xform_in <= rand_xform();
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result word is checked against the oldest prediction.
    always @(posedge i_clk) begin : monitor
        t_out want;
        logic [11:0][31:0] got_w;
        logic [11:0][31:0] want_w;
        if (i_rst_n) begin
            if ($isunknown(o_valid)) begin
                report_error("o_valid is unknown");
            end else if (o_valid) begin
                if (awaited_matrices.size() == 0) begin
                    report_error($sformatf("result word %0d arrived with nothing awaited",
                                           matrices_seen));
                end else begin
                    want = awaited_matrices.pop_front();
                    got_w = o_result;
                    want_w = want;
                    for (int i = 0; i < 12; i++) begin
                        if (got_w[11-i] !== want_w[11-i]) begin
                            report_error($sformatf("word %0d %s: got %h, expected %h",
                                                   matrices_seen, field_names[i],
                                                   got_w[11-i], want_w[11-i]));
                        end
                    end
                end
                matrices_seen++;
            end
        end
    end

    // Stimulus: directed corner words, then random phases at idle rates of 0, 74, 0 and 37 percent.
    initial begin : stimulus
        int phase_idle [N_PHASES];
        int waited;
        phase_idle = '{0, 74, 0, 37};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Zero input, identity rotation, and the extremes of every field.
        pending_xforms.push_back(make_xform('0, '0, '0, '0, '0, '0, '0, '0, '0, '0));
        pending_xforms.push_back(make_xform('0, '0, '0, 16'h7FFF, 16'h0100, 16'h0100, 16'h0100,
                                            '0, '0, '0));
        pending_xforms.push_back(make_xform(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                            16'h7FFF, 16'h7FFF, 16'h7FFF,
                                            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        pending_xforms.push_back(make_xform(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                            16'h8000, 16'h8000, 16'h8000,
                                            32'h80000000, 32'h80000000, 32'h80000000));
        pending_xforms.push_back(make_xform(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                            16'h7FFF, 16'h7FFF, 16'h7FFF,
                                            32'hFFFFFFFF, 32'h00000001, 32'h00000000));
        // A single axis at full magnitude.
        pending_xforms.push_back(make_xform(16'h7FFF, '0, '0, '0, 16'h0100, 16'h0100, 16'h0100,
                                            32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF));
        pending_xforms.push_back(make_xform('0, 16'h7FFF, '0, '0, 16'h0100, 16'hFF00, 16'h0100,
                                            '0, '0, '0));
        pending_xforms.push_back(make_xform('0, '0, 16'h8000, '0, 16'h0100, 16'h0100, 16'hFF00,
                                            '0, '0, '0));
        pending_xforms.push_back(make_xform('0, '0, '0, 16'h8000, 16'hFF00, 16'hFF00, 16'hFF00,
                                            '0, '0, '0));
        // A quaternion far from unit length, taken as it stands.
        pending_xforms.push_back(make_xform(16'd20000, -16'sd20000, 16'd30000, 16'd10000,
                                            16'h0200, 16'h0080, 16'hFE00,
                                            32'h00010000, 32'hFFFF0000, 32'h12345678));
        // Products landing exactly on the rounding midpoint, both signs.
        pending_xforms.push_back(make_xform(16'd16, 16'd16, 16'd16, 16'd16,
                                            16'd2048, 16'd2048, 16'd2048, '0, '0, '0));
        pending_xforms.push_back(make_xform(16'd16, 16'd16, 16'd16, 16'd16,
                                            -16'sd2048, -16'sd2048, -16'sd2048, '0, '0, '0));
        pending_xforms.push_back(make_xform(16'h1234, 16'hEDCB, 16'h0F0F, 16'hF0F0,
                                            16'h0001, 16'hFFFF, 16'h0001, '0, '0, '0));
        pending_xforms.push_back(make_xform(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001,
                                            16'h8000, 16'h7FFF, 16'h0001,
                                            32'hAAAAAAAA, 32'h55555555, 32'hAAAAAAAA));
        pending_xforms.push_back(make_xform(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                            16'hAAAA, 16'h5555, 16'hAAAA,
                                            32'h55555555, 32'hAAAAAAAA, 32'h55555555));

        for (int phase = 0; phase < N_PHASES; phase++) begin
            idle_pct = phase_idle[phase];
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                pending_xforms.push_back(rand_xform());
            end
            while (pending_xforms.size() != 0 || start || awaited_matrices.size() != 0) begin
                @(negedge i_clk);
            end
        end

        // Let any stray word drain through the pipeline before the verdict.
        waited = 0;
        while (awaited_matrices.size() != 0 && waited < 1000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (LATENCY + 8) @(negedge i_clk);
        if (awaited_matrices.size() != 0) begin
            report_error($sformatf("%0d result words never arrived", awaited_matrices.size()));
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Guard against a hung run.
    initial begin : watchdog
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
